/* src/pfa_pkg.sv */
// Shared constants and types of the paged frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

    // Frame table geometry
    localparam int NUM_FRAMES = 256;
    localparam int OWNER_BITS = 8;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    // Field widths
    localparam int BYTES_W = 24;
    localparam int FB_W    = 17;
    localparam int FIU_W   = 9;

    // Divider steps, one quotient bit each
    localparam int DIV_STEPS = BYTES_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [7:0] REG_FRAME_BYTES   = 8'd0;
    localparam logic [7:0] REG_FRAMES_IN_USE = 8'd1;

    // Request kinds
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Divider result bundle
    typedef struct packed {
        logic               done;
        logic [BYTES_W-1:0] quot;
        logic               rem_nz;
    } div_res_t;

endpackage

/* src/pfa_div.sv */
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module pfa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pfa_pkg::BYTES_W-1:0] dividend,
    input  logic [pfa_pkg::FB_W-1:0]    divisor,
    output pfa_pkg::div_res_t         res
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [pfa_pkg::DCNT_W-1:0]  cnt_reg;
    logic [pfa_pkg::FB_W-1:0]    rem_reg;
    logic [pfa_pkg::FB_W-1:0]    dsr_reg;
    logic [pfa_pkg::BYTES_W-1:0] quo_reg;

    logic [pfa_pkg::FB_W:0] shifted;
    logic [pfa_pkg::FB_W:0] trial;
    logic                   ge;

    // Shift in the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[pfa_pkg::BYTES_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pfa_pkg::DCNT_W'(pfa_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[pfa_pkg::FB_W-1:0] : shifted[pfa_pkg::FB_W-1:0];
            quo_reg <= {quo_reg[pfa_pkg::BYTES_W-2:0], ge};
        end
    end

    assign res.done   = done_reg;
    assign res.quot   = quo_reg;
    assign res.rem_nz = |rem_reg;

endmodule

/* src/paged_frame_allocator_unit.sv */
// Paged frame allocator: owner table, free-frame scan and page totals.
// Allocate: ceiling division on the divider, a check against the free count (a refusal skips
//   the scan), then a scan down from the pool top, one frame per cycle, until enough are found.
// Release: pipelined owner reads over every frame, clearing the marks of the frames it owns.
// One request at a time: in_ready returns with out_valid, later while a result is still held.
// Reset clears the taken marks and totals and restores the default config at once; the owner memory is not cleared.
`timescale 1ns / 1ps

module paged_frame_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  owner_id,
    input  logic [23:0] bytes_required,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [7:0]  start_frame,
    output logic [8:0]  frames_moved,
    output logic [31:0] page_in_total,
    output logic [31:0] page_out_total,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int IW = pfa_pkg::IDX_W;
    localparam int CW = pfa_pkg::CNT_W;
    localparam int OW = pfa_pkg::OWNER_BITS;
    localparam int NF = pfa_pkg::NUM_FRAMES;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_ALLOC = 3'd3;
    localparam logic [2:0] ST_REL   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [pfa_pkg::FB_W-1:0]   fb_reg, fb_next;
    logic [CW-1:0]              limit_reg, limit_next;
    logic [NF-1:0]              taken_reg, taken_next;
    logic [CW-1:0]              free_reg, free_next;
    logic [31:0]                pin_reg, pin_next;
    logic [31:0]                pout_reg, pout_next;

    logic [OW-1:0]              who_reg, who_next;
    logic [pfa_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [pfa_pkg::BYTES_W-1:0] need_reg, need_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic [CW-1:0]              left_reg, left_next;
    logic                       first_reg, first_next;
    logic                       zero_reg, zero_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic [IW-1:0]              chk_idx_reg, chk_idx_next;
    logic [CW-1:0]              freed_reg, freed_next;
    logic                       stat_reg, stat_next;
    logic [IW-1:0]              start_reg, start_next;
    logic [CW-1:0]              moved_reg, moved_next;

    logic                       ov_reg, ov_next;
    logic                       o_stat_reg, o_stat_next;
    logic [7:0]                 o_start_reg, o_start_next;
    logic [8:0]                 o_moved_reg, o_moved_next;
    logic [31:0]                o_pin_reg, o_pin_next;
    logic [31:0]                o_pout_reg, o_pout_next;

    // owner memory
    logic [OW-1:0]              owner_mem [0:NF-1];
    logic [OW-1:0]              owner_rd_reg;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;

    logic                       div_start;
    logic [pfa_pkg::FB_W-1:0]   div_dsr;
    pfa_pkg::div_res_t          div_res;

    logic [IW-1:0]              scan_idx;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign div_dsr   = (fb_reg == '0) ? pfa_pkg::FB_W'(1) : fb_reg;
    assign scan_idx  = IW'(scan_reg - 1'b1);

    pfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bytes_reg),
        .divisor  (div_dsr),
        .res      (div_res)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        state_next   = state_reg;
        fb_next      = fb_reg;
        limit_next   = limit_reg;
        taken_next   = taken_reg;
        free_next    = free_reg;
        pin_next     = pin_reg;
        pout_next    = pout_reg;
        who_next     = who_reg;
        bytes_next   = bytes_reg;
        need_next    = need_reg;
        scan_next    = scan_reg;
        left_next    = left_reg;
        first_next   = first_reg;
        zero_next    = zero_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        freed_next   = freed_reg;
        stat_next    = stat_reg;
        start_next   = start_reg;
        moved_next   = moved_reg;
        ov_next      = ov_reg;
        o_stat_next  = o_stat_reg;
        o_start_next = o_start_reg;
        o_moved_next = o_moved_reg;
        o_pin_next   = o_pin_reg;
        o_pout_next  = o_pout_reg;
        div_start    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = scan_idx;

        // result handed off
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        // configuration writes (block is idle)
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pfa_pkg::REG_FRAME_BYTES)
            begin
                fb_next = cfg_data;
            end
            else if (cfg_index == pfa_pkg::REG_FRAMES_IN_USE)
            begin
                if (32'(cfg_data[pfa_pkg::FIU_W-1:0]) > NF)
                begin
                    limit_next = CW'(NF);
                end
                else
                begin
                    limit_next = CW'(cfg_data[pfa_pkg::FIU_W-1:0]);
                end
                taken_next = '0;
                free_next  = limit_next;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    who_next   = owner_id[OW-1:0];
                    bytes_next = bytes_required;
                    stat_next  = 1'b0;
                    start_next = '0;
                    moved_next = '0;
                    if (req_type == pfa_pkg::REQ_RELEASE)
                    begin
                        idx_next   = '0;
                        freed_next = '0;
                        state_next = ST_REL;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // divider is started in the cycle after the bytes are latched
                if (!div_res.done && !first_reg)
                begin
                    div_start  = 1'b1;
                    first_next = 1'b1;
                end
                if (div_res.done)
                begin
                    need_next  = div_res.quot + pfa_pkg::BYTES_W'(div_res.rem_nz);
                    state_next = ST_CHK;
                end
            end

            ST_CHK:
            begin
                scan_next  = limit_reg;
                first_next = 1'b1;
                if (need_reg == '0)
                begin
                    zero_next  = 1'b1;
                    left_next  = CW'(1);
                    state_next = ST_ALLOC;
                end
                else if (need_reg > pfa_pkg::BYTES_W'(free_reg))
                begin
                    stat_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    zero_next  = 1'b0;
                    left_next  = CW'(need_reg);
                    free_next  = free_reg - CW'(need_reg);
                    pin_next   = pin_reg + 32'(need_reg);
                    moved_next = CW'(need_reg);
                    state_next = ST_ALLOC;
                end
            end

            ST_ALLOC:
            begin
                // one frame per cycle, highest first
                if (scan_reg == '0 || left_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    scan_next = scan_reg - 1'b1;
                    if (!taken_reg[scan_idx])
                    begin
                        left_next = left_reg - 1'b1;
                        if (first_reg)
                        begin
                            start_next = scan_idx;
                            first_next = 1'b0;
                        end
                        if (!zero_reg)
                        begin
                            taken_next[scan_idx] = 1'b1;
                            mem_we = 1'b1;
                        end
                    end
                end
            end

            ST_REL:
            begin
                // issue a read, check the frame read last cycle
                if (idx_reg != CW'(NF))
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = IW'(idx_reg);
                    idx_next     = idx_reg + 1'b1;
                end
                if (chk_vld_reg && taken_reg[chk_idx_reg] && owner_rd_reg == who_reg)
                begin
                    taken_next[chk_idx_reg] = 1'b0;
                    freed_next = freed_reg + 1'b1;
                end
                if (idx_reg == CW'(NF) && !chk_vld_reg)
                begin
                    free_next  = free_reg + freed_reg;
                    pout_next  = pout_reg + 32'(freed_reg);
                    moved_next = freed_reg;
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                first_next = 1'b0;
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    o_stat_next  = stat_reg;
                    o_start_next = 8'(start_reg);
                    o_moved_next = 9'(moved_reg);
                    o_pin_next   = pin_reg;
                    o_pout_next  = pout_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fb_reg      <= pfa_pkg::FB_W'(16);
            limit_reg   <= CW'(NF);
            taken_reg   <= '0;
            free_reg    <= CW'(NF);
            pin_reg     <= '0;
            pout_reg    <= '0;
            chk_vld_reg <= 1'b0;
            first_reg   <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fb_reg      <= fb_next;
            limit_reg   <= limit_next;
            taken_reg   <= taken_next;
            free_reg    <= free_next;
            pin_reg     <= pin_next;
            pout_reg    <= pout_next;
            chk_vld_reg <= chk_vld_next;
            first_reg   <= first_next;
            ov_reg      <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        who_reg     <= who_next;
        bytes_reg   <= bytes_next;
        need_reg    <= need_next;
        scan_reg    <= scan_next;
        left_reg    <= left_next;
        zero_reg    <= zero_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        freed_reg   <= freed_next;
        stat_reg    <= stat_next;
        start_reg   <= start_next;
        moved_reg   <= moved_next;
        o_stat_reg  <= o_stat_next;
        o_start_reg <= o_start_next;
        o_moved_reg <= o_moved_next;
        o_pin_reg   <= o_pin_next;
        o_pout_reg  <= o_pout_next;
    end

    // Owner memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            owner_mem[mem_waddr] <= who_reg;
        end
        owner_rd_reg <= owner_mem[IW'(idx_reg)];
    end

    assign out_valid      = ov_reg;
    assign status         = o_stat_reg;
    assign start_frame    = o_start_reg;
    assign frames_moved   = o_moved_reg;
    assign page_in_total  = o_pin_reg;
    assign page_out_total = o_pout_reg;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the paged frame allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

    localparam int          PHASES         = 10;
    localparam int          ITEMS_PER_PHASE = 173;
    localparam int          HOLD_CYCLES    = 3000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          TAIL_CYCLES    = 300;
    localparam int          MAX_PRINTS     = 100;
    localparam longint      LIMIT_CYCLES   = 3000000;
    localparam logic [7:0]  REG_UNKNOWN    = 8'd2;

    // One result item of the block
    typedef struct packed {
        logic        status;
        logic [7:0]  start;
        logic [8:0]  moved;
        logic [31:0] pin;
        logic [31:0] pout;
    } alloc_result_t;

    // One row of the directed table
    typedef struct {
        logic          kind;
        logic [7:0]    who;
        logic [23:0]   nbytes;
        bit            typed;
        alloc_result_t want;
    } request_row_t;

    // DUT signals, inputs known from time zero
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic        req_type       = 1'b0;
    logic [7:0]  owner_id       = '0;
    logic [23:0] bytes_required = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        status;
    logic [7:0]  start_frame;
    logic [8:0]  frames_moved;
    logic [31:0] page_in_total;
    logic [31:0] page_out_total;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index      = '0;
    logic [16:0] cfg_data       = '0;

    // Allocator shadow state
    logic [7:0]  holder     [pfa_pkg::NUM_FRAMES];
    bit          frame_held [pfa_pkg::NUM_FRAMES];
    int          free_frames;
    logic [31:0] pages_in;
    logic [31:0] pages_out;
    logic [16:0] frame_size;
    logic [8:0]  pool_frames;

    alloc_result_t expected_results[$];
    request_row_t  dir_rows[$];
    int            error_count  = 0;
    int            result_count = 0;
    longint        cycle_count  = 0;
    bit            hold_off_req = 1'b0;
    bit            quiet        = 1'b0;

    paged_frame_allocator_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .owner_id       (owner_id),
        .bytes_required (bytes_required),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .start_frame    (start_frame),
        .frames_moved   (frames_moved),
        .page_in_total  (page_in_total),
        .page_out_total (page_out_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d items still pending",
                     cycle_count, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pool_limit();
        return (pool_frames > pfa_pkg::NUM_FRAMES) ? pfa_pkg::NUM_FRAMES : int'(pool_frames);
    endfunction

    // Rebuild the pool: every frame free, totals kept
    function automatic void clear_pool();
        int i;
        for (i = 0; i < pfa_pkg::NUM_FRAMES; i++)
        begin
            holder[i]     = '0;
            frame_held[i] = 1'b0;
        end
        free_frames = pool_limit();
    endfunction

    // Shadow allocator: applies one request and returns the result it should give
    function automatic alloc_result_t serve_request(logic kind, logic [7:0] who,
                                                    logic [23:0] nbytes);
        alloc_result_t   r;
        longint unsigned fb_eff;
        longint unsigned need;
        int              limit;
        int              left;
        int              freed;
        int              i;
        bit              found;
        r     = '0;
        limit = pool_limit();
        if (kind == pfa_pkg::REQ_ALLOC)
        begin
            fb_eff = (frame_size == 0) ? 1 : frame_size;
            need   = (nbytes + fb_eff - 1) / fb_eff;
            if (need == 0)
            begin
                // zero size: report highest free frame, take nothing
                found = 1'b0;
                for (i = limit - 1; i >= 0; i--)
                begin
                    if (!found && !frame_held[i])
                    begin
                        r.start = i[7:0];
                        found   = 1'b1;
                    end
                end
            end
            else if (need > longint'(free_frames))
            begin
                r.status = 1'b1;
            end
            else
            begin
                // take the highest free frames
                found = 1'b0;
                left  = int'(need);
                for (i = limit - 1; i >= 0 && left > 0; i--)
                begin
                    if (!frame_held[i])
                    begin
                        if (!found)
                        begin
                            r.start = i[7:0];
                            found   = 1'b1;
                        end
                        frame_held[i] = 1'b1;
                        holder[i]     = who;
                        left--;
                    end
                end
                free_frames -= int'(need);
                pages_in     = pages_in + 32'(need);
                r.moved      = need[8:0];
            end
        end
        else
        begin
            freed = 0;
            for (i = 0; i < pfa_pkg::NUM_FRAMES; i++)
            begin
                if (frame_held[i] && holder[i] == who)
                begin
                    frame_held[i] = 1'b0;
                    holder[i]     = '0;
                    freed++;
                end
            end
            free_frames += freed;
            pages_out    = pages_out + 32'(freed);
            r.moved      = 9'(freed);
        end
        r.pin  = pages_in;
        r.pout = pages_out;
        return r;
    endfunction

    // Append one expected result to the scoreboard
    task automatic expect_result(alloc_result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (error_count < MAX_PRINTS)
            $display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
        error_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("item with nothing pending", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (start_frame !== want.start)
                    report_mismatch("start_frame", start_frame, want.start);
                if (frames_moved !== want.moved)
                    report_mismatch("frames_moved", frames_moved, want.moved);
                if (page_in_total !== want.pin)
                    report_mismatch("page_in_total", page_in_total, want.pin);
                if (page_out_total !== want.pout)
                    report_mismatch("page_out_total", page_out_total, want.pout);
            end
            result_count++;
        end
    end

    // Result side: random stalls, calm stretches, one long hold-off on request
    initial
    begin : result_sink
        int  n;
        int  stretch;
        bit  calm;
        stretch = 0;
        calm    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                stretch = $urandom_range(200, 2000);
                calm    = ($urandom_range(0, 2) == 0);
            end
            stretch--;
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    n++;
                end
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && !calm && $urandom_range(0, 99) < 20)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one request and wait until it is taken; valid is left high
    task automatic send_request(logic kind, logic [7:0] who, logic [23:0] nbytes,
                                output alloc_result_t predicted);
        req_type       <= kind;
        owner_id       <= who;
        bytes_required <= nbytes;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = serve_request(kind, who, nbytes);
    endtask

    // Request side gap
    task automatic maybe_idle(bit calm);
        if (!quiet && !calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Register write; valid is left high for a following write
    task automatic write_register(logic [7:0] idx, logic [16:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == pfa_pkg::REG_FRAME_BYTES)
        begin
            frame_size = data;
        end
        else if (idx == pfa_pkg::REG_FRAMES_IN_USE)
        begin
            pool_frames = data[8:0];
            clear_pool();
        end
    endtask

    // Wait until every pending result has come
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Byte count that needs a given number of frames at the current frame size, capped at 24'hFFFFFF
    function automatic logic [23:0] bytes_for(int frames);
        longint unsigned fb_eff;
        longint unsigned b;
        fb_eff = (frame_size == 0) ? 1 : frame_size;
        b      = longint'(frames) * fb_eff;
        b      = b - $urandom_range(0, int'(fb_eff - 1));
        if (b > 24'hFFFFFF)
            b = 24'hFFFFFF;
        return b[23:0];
    endfunction

    // Append one row to the directed table
    function automatic void add_row(logic kind, logic [7:0] who, logic [23:0] nbytes,
                                    bit typed, logic st, logic [7:0] start,
                                    logic [8:0] moved, logic [31:0] pin,
                                    logic [31:0] pout);
        request_row_t row;
        row.kind   = kind;
        row.who    = who;
        row.nbytes = nbytes;
        row.typed  = typed;
        row.want   = '{status: st, start: start, moved: moved, pin: pin, pout: pout};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Stimulus
    initial
    begin : stimulus
        alloc_result_t predicted;
        int unsigned   phase_fb  [PHASES];
        int unsigned   phase_fiu [PHASES];
        logic [16:0]   fb_val;
        logic [8:0]    fiu_val;
        logic [7:0]    salt;
        logic [7:0]    who;
        logic          kind;
        logic [23:0]   nbytes;
        int            r;
        int            p;
        int            n;
        bit            calm;

        phase_fb  = '{1, 65536, 0, 17'h1FFFF, 16, 3, 64, 0, 0, 16};
        phase_fiu = '{256, 256, 8, 511, 1, 0, 37, 0, 0, 256};

        // shadow reset values
        frame_size  = 17'd16;
        pool_frames = 9'd256;
        pages_in    = '0;
        pages_out   = '0;
        clear_pool();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset configuration: 16-unit frames, 256 frames
        add_row(pfa_pkg::REQ_ALLOC,   8'd0,   24'd0,      1, 0, 255, 0,   0,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'd1,   24'd1,      1, 0, 255, 1,   1,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'd2,   24'd16,     1, 0, 254, 1,   2,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'd2,   24'd17,     1, 0, 253, 2,   4,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'd3,   24'hFFFFFF, 1, 1, 0,   0,   4,   0);
        add_row(pfa_pkg::REQ_RELEASE, 8'd2,   24'd0,      1, 0, 0,   3,   4,   3);
        add_row(pfa_pkg::REQ_ALLOC,   8'd0,   24'd0,      1, 0, 254, 0,   4,   3);
        // one frame more than is free, then exactly what is free
        add_row(pfa_pkg::REQ_ALLOC,   8'd4,   24'd4081,   1, 1, 0,   0,   4,   3);
        add_row(pfa_pkg::REQ_ALLOC,   8'd4,   24'd4080,   1, 0, 254, 255, 259, 3);
        // pool full: zero size reports frame 0, any size is refused
        add_row(pfa_pkg::REQ_ALLOC,   8'd0,   24'd0,      1, 0, 0,   0,   259, 3);
        add_row(pfa_pkg::REQ_ALLOC,   8'd5,   24'd1,      1, 1, 0,   0,   259, 3);
        add_row(pfa_pkg::REQ_RELEASE, 8'd9,   24'hFFFFFF, 1, 0, 0,   0,   259, 3);
        add_row(pfa_pkg::REQ_RELEASE, 8'd4,   24'd0,      1, 0, 0,   255, 259, 258);
        add_row(pfa_pkg::REQ_RELEASE, 8'd1,   24'd0,      1, 0, 0,   1,   259, 259);
        // whole pool to one owner and back
        add_row(pfa_pkg::REQ_ALLOC,   8'd255, 24'd4096,   1, 0, 255, 256, 515, 259);
        add_row(pfa_pkg::REQ_RELEASE, 8'd255, 24'd0,      1, 0, 0,   256, 515, 515);
        add_row(pfa_pkg::REQ_ALLOC,   8'hAA,  24'h5A5A5A, 0, 0, 0,   0,   0,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'h55,  24'h000123, 0, 0, 0,   0,   0,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'h80,  24'd100,    0, 0, 0,   0,   0,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'h55,  24'd32,     0, 0, 0,   0,   0,   0);
        add_row(pfa_pkg::REQ_RELEASE, 8'h55,  24'h00FFFF, 0, 0, 0,   0,   0,   0);
        add_row(pfa_pkg::REQ_ALLOC,   8'h80,  24'd0,      0, 0, 0,   0,   0,   0);
        add_row(pfa_pkg::REQ_RELEASE, 8'h80,  24'd0,      0, 0, 0,   0,   0,   0);

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].kind, dir_rows[i].who, dir_rows[i].nbytes, predicted);
            expect_result(dir_rows[i].typed ? dir_rows[i].want : predicted);
            maybe_idle(1'b0);
        end

        // Random phases, each under its own configuration
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);

            fb_val  = phase_fb[p][16:0];
            fiu_val = phase_fiu[p][8:0];
            if (p == 7)
                fb_val = 17'($urandom_range(1, 400));
            if (p == 8)
            begin
                fb_val  = 17'($urandom_range(1, 400));
                fiu_val = 9'($urandom_range(1, 256));
            end
            write_register(pfa_pkg::REG_FRAME_BYTES, fb_val);
            // frame size change alone keeps held frames
            if (p != 7)
                write_register(pfa_pkg::REG_FRAMES_IN_USE, {8'h00, fiu_val});
            if (p == 3)
                write_register(REG_UNKNOWN, 17'($urandom_range(0, 17'h1FFFF)));
            cfg_valid <= 1'b0;

            if (p == PHASES - 1)
                quiet = 1'b1;
            salt = 8'($urandom_range(0, 255));
            calm = 1'b0;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    // ordinary allocate, mostly a few frames
                    kind   = pfa_pkg::REQ_ALLOC;
                    who    = salt ^ 8'($urandom_range(0, 5));
                    nbytes = ($urandom_range(0, 9) == 0) ? bytes_for($urandom_range(1, 256))
                                                        : bytes_for($urandom_range(1, 6));
                end
                else if (r < 50)
                begin
                    kind   = pfa_pkg::REQ_ALLOC;
                    who    = 8'($urandom_range(0, 255));
                    nbytes = '0;
                end
                else if (r < 78)
                begin
                    kind   = pfa_pkg::REQ_RELEASE;
                    who    = salt ^ 8'($urandom_range(0, 5));
                    nbytes = 24'($urandom_range(0, 24'hFFFFFF));
                end
                else if (r < 88)
                begin
                    kind   = pfa_pkg::REQ_RELEASE;
                    who    = 8'($urandom_range(0, 255));
                    nbytes = 24'($urandom_range(0, 24'hFFFFFF));
                end
                else
                begin
                    // raw noise across the whole size range
                    kind   = pfa_pkg::REQ_ALLOC;
                    who    = 8'($urandom_range(0, 255));
                    nbytes = 24'($urandom_range(0, 24'hFFFFFF));
                end

                send_request(kind, who, nbytes, predicted);
                expect_result(predicted);

                // long receiver stall while requests keep coming
                if (p == 1 && n == 40)
                    hold_off_req = 1'b1;
                // sender waits for every pending result
                if (p == 2 && n == 60)
                begin
                    drain_results();
                    @(posedge clk);
                end
                else
                begin
                    maybe_idle(calm);
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
src/pfa_pkg.sv
src/pfa_div.sv
src/paged_frame_allocator_unit.sv
tb/tb.sv
